/* src/xmlext_pkg.sv */
// Shared types and constants of the XML element text extractor.
// Used by the configuration, parser, output buffer and top-level files.
package xmlext_pkg;

    localparam int NAME_MAX_DEF  = 16;
    localparam int VALUE_MAX_DEF = 4096;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_NAME_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd3;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [3:0] PH_SEARCH     = 4'd0;
    localparam logic [3:0] PH_OPEN_NAME  = 4'd1;
    localparam logic [3:0] PH_SPACE      = 4'd2;
    localparam logic [3:0] PH_SKIP       = 4'd3;
    localparam logic [3:0] PH_TEXT       = 4'd4;
    localparam logic [3:0] PH_SLASH      = 4'd5;
    localparam logic [3:0] PH_CLOSE_NAME = 4'd6;
    localparam logic [3:0] PH_CLOSE_GT   = 4'd7;
    localparam logic [3:0] PH_FINISHED   = 4'd8;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OVERFLOW = 3'd1;
    localparam logic [2:0] ST_NO_SLASH = 3'd2;
    localparam logic [2:0] ST_MISMATCH = 3'd3;
    localparam logic [2:0] ST_NO_GT    = 3'd4;
    localparam logic [2:0] ST_ENDED    = 3'd5;

    localparam logic KIND_TEXT   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [127:0] name_chars;
        logic [4:0]   tag_len;
        logic [12:0]  capacity;
    } t_cfg;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  text_byte;
        logic [2:0]  status_code;
        logic [11:0] text_length;
    } t_res;

endpackage

/* src/xmlext_in_if.sv */
// Document byte channel of the XML element text extractor.
// Depends on nothing.
interface xmlext_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] doc_byte;
    logic       doc_last;

    modport source (output valid, output doc_byte, output doc_last, input ready);
    modport sink   (input valid, input doc_byte, input doc_last, output ready);
endinterface

/* src/xmlext_out_if.sv */
// Result channel of the XML element text extractor.
// Depends on nothing.
interface xmlext_out_if;
    logic        valid;
    logic        ready;
    logic        out_kind;
    logic [7:0]  text_byte;
    logic [2:0]  status_code;
    logic [11:0] text_length;

    modport source (output valid, output out_kind, output text_byte, output status_code,
                    output text_length, input ready);
    modport sink   (input valid, input out_kind, input text_byte, input status_code,
                    input text_length, output ready);
endinterface

/* src/xmlext_cfg.sv */
// Configuration registers and their clamped effective values.
// Depends on xmlext_pkg.
module xmlext_cfg #(
    parameter int NAME_MAX  = xmlext_pkg::NAME_MAX_DEF,
    parameter int VALUE_MAX = xmlext_pkg::VALUE_MAX_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [xmlext_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [xmlext_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output xmlext_pkg::t_cfg                   o_cfg
);
    localparam logic [4:0]  NMAX = 5'(NAME_MAX);
    localparam logic [16:0] VMAX = 17'(VALUE_MAX);

    logic [63:0] r_name_low;
    logic [63:0] r_name_high;
    logic [4:0]  r_tag_len;
    logic [12:0] r_capacity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_low  <= '0;
            r_name_high <= '0;
            r_tag_len   <= 5'd1;
            r_capacity  <= 13'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                xmlext_pkg::CFG_NAME_LOW:  r_name_low  <= i_cfg_data;
                xmlext_pkg::CFG_NAME_HIGH: r_name_high <= i_cfg_data;
                xmlext_pkg::CFG_NAME_LEN:  r_tag_len   <= i_cfg_data[4:0];
                xmlext_pkg::CFG_CAPACITY:  r_capacity  <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.name_chars = {r_name_high, r_name_low};
        if (r_tag_len == 5'd0) begin
            o_cfg.tag_len = 5'd1;
        end else if (r_tag_len > NMAX) begin
            o_cfg.tag_len = NMAX;
        end else begin
            o_cfg.tag_len = r_tag_len;
        end
        if (r_capacity == 13'd0) begin
            o_cfg.capacity = 13'd1;
        end else if ({4'b0, r_capacity} > VMAX) begin
            o_cfg.capacity = VMAX[12:0];
        end else begin
            o_cfg.capacity = r_capacity;
        end
    end
endmodule

/* src/xmlext_parser.sv */
// Input register, parse state and per-byte decode of the document stream.
// Depends on xmlext_pkg and xmlext_in_if.
module xmlext_parser #(
    parameter int NAME_MAX  = xmlext_pkg::NAME_MAX_DEF,
    parameter int VALUE_MAX = xmlext_pkg::VALUE_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xmlext_pkg::t_cfg  i_cfg,
    xmlext_in_if.sink         i_doc,
    input  logic              i_space,
    output logic              o_res_vld,
    output xmlext_pkg::t_res  o_res
);
    localparam int PW = (NAME_MAX < 1) ? 1 : $clog2(NAME_MAX + 1);
    localparam int CW = $clog2(VALUE_MAX + 1);

    logic          r_in_vld;
    logic [7:0]    r_in_byte;
    logic          r_in_last;
    logic [3:0]    r_phase;
    logic [PW-1:0] r_pos;
    logic [CW-1:0] r_cnt;

    logic [3:0]    n_phase;
    logic [PW-1:0] n_pos;
    logic [CW-1:0] n_cnt;

    logic          advance;
    logic [PW+3:0] pos_ext;
    logic [7:0]    name_ch;
    logic [PW:0]   pos_inc;
    logic          name_done;
    logic [CW-1:0] cnt_inc;
    logic          cap_hit;
    logic [CW+11:0] cnt_ext;
    logic          status;
    logic          text;
    logic [2:0]    st_code;
    logic [11:0]   st_len;

    assign advance     = r_in_vld && i_space;
    assign i_doc.ready = i_rst_n && (!r_in_vld || advance);

    assign pos_ext   = {4'b0, r_pos};
    assign name_ch   = i_cfg.name_chars[{pos_ext[3:0], 3'b000} +: 8];
    assign pos_inc   = {1'b0, r_pos} + 1'b1;
    assign name_done = {5'b0, pos_inc} >= {{(PW + 1){1'b0}}, i_cfg.tag_len};
    assign cnt_inc   = r_cnt + 1'b1;
    assign cap_hit   = {13'b0, cnt_inc} >= {{CW{1'b0}}, i_cfg.capacity};
    assign cnt_ext   = {12'b0, r_cnt};

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        status  = 1'b0;
        text    = 1'b0;
        st_code = xmlext_pkg::ST_OK;
        st_len  = '0;
        case (r_phase)
            xmlext_pkg::PH_SEARCH: begin
                if (r_in_byte == xmlext_pkg::CH_LT) begin
                    n_phase = xmlext_pkg::PH_OPEN_NAME;
                    n_pos   = '0;
                end
            end
            xmlext_pkg::PH_OPEN_NAME: begin
                if (r_in_byte == name_ch) begin
                    n_pos = pos_inc[PW-1:0];
                    if (name_done) begin
                        n_phase = xmlext_pkg::PH_SPACE;
                    end
                end else begin
                    n_pos   = '0;
                    n_phase = xmlext_pkg::PH_SEARCH;
                end
            end
            xmlext_pkg::PH_SPACE: begin
                n_pos   = '0;
                n_phase = (r_in_byte == xmlext_pkg::CH_SPACE) ? xmlext_pkg::PH_SKIP
                                                              : xmlext_pkg::PH_SEARCH;
            end
            xmlext_pkg::PH_SKIP: begin
                if (r_in_byte == xmlext_pkg::CH_GT) begin
                    n_cnt   = '0;
                    n_phase = xmlext_pkg::PH_TEXT;
                end
            end
            xmlext_pkg::PH_TEXT: begin
                if (r_in_byte == xmlext_pkg::CH_LT) begin
                    n_pos   = '0;
                    n_phase = xmlext_pkg::PH_SLASH;
                end else begin
                    n_cnt = cnt_inc;
                    if (cap_hit) begin
                        status  = 1'b1;
                        st_code = xmlext_pkg::ST_OVERFLOW;
                    end else begin
                        text = 1'b1;
                    end
                end
            end
            xmlext_pkg::PH_SLASH: begin
                if (r_in_byte == xmlext_pkg::CH_SLASH) begin
                    n_phase = xmlext_pkg::PH_CLOSE_NAME;
                end else begin
                    status  = 1'b1;
                    st_code = xmlext_pkg::ST_NO_SLASH;
                end
            end
            xmlext_pkg::PH_CLOSE_NAME: begin
                if (r_in_byte == name_ch) begin
                    n_pos = pos_inc[PW-1:0];
                    if (name_done) begin
                        n_phase = xmlext_pkg::PH_CLOSE_GT;
                    end
                end else begin
                    status  = 1'b1;
                    st_code = xmlext_pkg::ST_MISMATCH;
                end
            end
            xmlext_pkg::PH_CLOSE_GT: begin
                status = 1'b1;
                if (r_in_byte == xmlext_pkg::CH_GT) begin
                    st_code = xmlext_pkg::ST_OK;
                    st_len  = cnt_ext[11:0];
                end else begin
                    st_code = xmlext_pkg::ST_NO_GT;
                end
            end
            default: ;
        endcase

        if (status) begin
            n_phase = xmlext_pkg::PH_FINISHED;
        end
        if (r_in_last) begin
            n_phase = xmlext_pkg::PH_SEARCH;
            n_pos   = '0;
            n_cnt   = '0;
        end

        o_res = '0;
        if (status) begin
            o_res.out_kind    = xmlext_pkg::KIND_STATUS;
            o_res.status_code = st_code;
            o_res.text_length = st_len;
        end else if (r_in_last && r_phase != xmlext_pkg::PH_FINISHED) begin
            o_res.out_kind    = xmlext_pkg::KIND_STATUS;
            o_res.status_code = xmlext_pkg::ST_ENDED;
        end else if (text) begin
            o_res.out_kind  = xmlext_pkg::KIND_TEXT;
            o_res.text_byte = r_in_byte;
        end
        o_res_vld = advance && (status || text ||
                                (r_in_last && r_phase != xmlext_pkg::PH_FINISHED));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_phase  <= xmlext_pkg::PH_SEARCH;
            r_pos    <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_doc.valid && i_doc.ready) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_cnt   <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_doc.valid && i_doc.ready) begin
            r_in_byte <= i_doc.doc_byte;
            r_in_last <= i_doc.doc_last;
        end
    end
endmodule

/* src/xmlext_outbuf.sv */
// Result register with a skid stage in front of the result channel.
// Depends on xmlext_pkg and xmlext_out_if.
module xmlext_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  xmlext_pkg::t_res  i_res,
    output logic              o_space,
    xmlext_out_if.source      o_res
);
    logic             r_out_vld;
    xmlext_pkg::t_res r_out;
    logic             r_skid_vld;
    xmlext_pkg::t_res r_skid;
    logic             pop;
    logic             out_free;

    assign pop      = r_out_vld && o_res.ready;
    assign out_free = !r_out_vld || (pop && !r_skid_vld);
    assign o_space  = !r_skid_vld;

    assign o_res.valid       = r_out_vld;
    assign o_res.out_kind    = r_out.out_kind;
    assign o_res.text_byte   = r_out.text_byte;
    assign o_res.status_code = r_out.status_code;
    assign o_res.text_length = r_out.text_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (pop && r_skid_vld) begin
                r_skid_vld <= 1'b0;
            end else if (i_push) begin
                r_out_vld <= 1'b1;
                if (!out_free) begin
                    r_skid_vld <= 1'b1;
                end
            end else if (pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_skid_vld) begin
            r_out <= r_skid;
        end else if (i_push && out_free) begin
            r_out <= i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end
endmodule

/* src/xml_element_text_extractor.sv */
// Top level of the XML element text extractor.
// Depends on xmlext_pkg, both channel interfaces, xmlext_cfg, xmlext_parser, xmlext_outbuf.
//
// The block takes one document byte per request and returns at most one result per byte:
// an inner text byte, or one final status per document (ok with the text length, overflow,
// no slash, closing name mismatch, no closing bracket, document ended). A byte is held in the
// input register and is decoded on its way into the result register, so the throughput is one
// byte per cycle while the result buffer has space; a two-entry result buffer keeps the sink's
// ready off the input side, and a stalled sink holds the input once both entries are full.
// The user must write configuration through the plain write port only while no document
// byte is in flight; the block itself does not enforce this.
module xml_element_text_extractor #(
    parameter int NAME_MAX  = xmlext_pkg::NAME_MAX_DEF,
    parameter int VALUE_MAX = xmlext_pkg::VALUE_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [xmlext_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [xmlext_pkg::CFG_DATA_W-1:0] i_cfg_data,
    xmlext_in_if.sink                         i_doc,
    xmlext_out_if.source                      o_res
);
    xmlext_pkg::t_cfg cfg;
    xmlext_pkg::t_res res;
    logic             res_vld;
    logic             space;

    xmlext_cfg #(
        .NAME_MAX  (NAME_MAX),
        .VALUE_MAX (VALUE_MAX)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    xmlext_parser #(
        .NAME_MAX  (NAME_MAX),
        .VALUE_MAX (VALUE_MAX)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_doc     (i_doc),
        .i_space   (space),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    xmlext_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_vld),
        .i_res   (res),
        .o_space (space),
        .o_res   (o_res)
    );
endmodule
